// File: rtl/sqct_pkg.sv
// ============================================================================
// sqct_pkg : shared types and constants for the sprite quad corner transform
// Widths, polynomial coefficients, pipeline depths and register indexes.
// ============================================================================
package sqct_pkg;

  localparam int POS_W     = 24;
  localparam int UV_W      = 20;
  localparam int DEN_W     = 16;
  localparam int TSUM_W    = 25;
  localparam int DIV_STEPS = UV_W;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int POS_STAGES = 8;
  localparam int RES_LAT   = DIV_LAT + 1;

  localparam int POLY_A  = 25736;
  localparam int POLY_B  = 10512;
  localparam int POLY_C  = 1160;
  localparam int Q14_ONE = 16384;

  typedef enum logic [1:0] {
    REG_ORIGIN_X       = 2'd0,
    REG_ORIGIN_Y       = 2'd1,
    REG_TEXTURE_WIDTH  = 2'd2,
    REG_TEXTURE_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef logic [POS_W-1:0] pos_word_t;

  // clamp a widened position to the signed 24-bit range
  function automatic pos_word_t sat_pos(input logic signed [32:0] v);
    pos_word_t r;
    if (v > 33'sd8388607) begin
      r = 24'h7FFFFF;
    end else if (v < -33'sd8388608) begin
      r = 24'h800000;
    end else begin
      r = v[POS_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/sprite_quad_corner_transform_unit.sv
// ============================================================================
// sprite_quad_corner_transform_unit : rotated sprite quad vertex setup
// Turns one sprite word into four corner vertex words with position and UV.
// ============================================================================
//
//  channel   handshake              payload
//  --------  ---------------------  ------------------------------------------
//  sprite    start / busy           place_*, tex_x/y/w/h, angle, flip, colour
//  vertex    result_valid strobe    pos_x/y, tex_u/v, vertex_colour, corner, last
//  config    cfg_we                 cfg_index, cfg_data
//
//  One vertex of a sprite word is issued per cycle; busy is high after each
//  accept until the last corner is issued, and a new sprite may be accepted
//  while that last corner is issued. The depth of the result path is set by the
//  20-step UV divider, and the position path is delayed to match. Synchronous
//  reset clears the sequencer and the valid line and restores the registers.
//  Vertex words cannot be held off by the receiver, so the pipeline always
//  advances.
//
module sprite_quad_corner_transform_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] place_x,
  input  logic [23:0] place_y,
  input  logic [23:0] place_w,
  input  logic [23:0] place_h,
  input  logic [23:0] tex_x,
  input  logic [23:0] tex_y,
  input  logic [23:0] tex_w,
  input  logic [23:0] tex_h,
  input  logic [15:0] angle,
  input  logic [1:0]  flip,
  input  logic [31:0] colour,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        result_valid,
  output logic [23:0] pos_x,
  output logic [23:0] pos_y,
  output logic [19:0] tex_u,
  output logic [19:0] tex_v,
  output logic [31:0] vertex_colour,
  output logic [1:0]  corner,
  output logic        last
);

  localparam int PDLY = sqct_pkg::DIV_LAT - sqct_pkg::POS_STAGES;

  // ---------------------------------------------------------------- registers
  logic signed [15:0] origin_x;
  logic signed [15:0] origin_y;
  logic [15:0]        texture_width;
  logic [15:0]        texture_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x       <= '0;
      origin_y       <= '0;
      texture_width  <= 16'd1;
      texture_height <= 16'd1;
    end else if (cfg_we) begin
      unique case (sqct_pkg::cfg_reg_t'(cfg_index))
        sqct_pkg::REG_ORIGIN_X:       origin_x       <= cfg_data;
        sqct_pkg::REG_ORIGIN_Y:       origin_y       <= cfg_data;
        sqct_pkg::REG_TEXTURE_WIDTH:  texture_width  <= cfg_data;
        sqct_pkg::REG_TEXTURE_HEIGHT: texture_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- issue
  // Hold the sprite word and step through its four corners, one per cycle.
  logic        active;
  logic [1:0]  k;
  logic        accept;
  logic signed [23:0] spr_px, spr_py;
  logic [23:0] spr_w, spr_h, spr_tx, spr_ty, spr_tw, spr_th;
  logic [15:0] spr_ang;
  logic [1:0]  spr_flip;
  logic [31:0] spr_col;

  assign busy   = active && (k != 2'd3);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      k      <= '0;
    end else if (accept) begin
      active <= 1'b1;
      k      <= '0;
    end else if (active) begin
      if (k == 2'd3) begin
        active <= 1'b0;
      end
      k <= k + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      spr_px   <= place_x;
      spr_py   <= place_y;
      spr_w    <= place_w;
      spr_h    <= place_h;
      spr_tx   <= tex_x;
      spr_ty   <= tex_y;
      spr_tw   <= tex_w;
      spr_th   <= tex_h;
      spr_ang  <= angle;
      spr_flip <= flip;
      spr_col  <= colour;
    end
  end

  logic right, bottom;
  assign right  = (k == 2'd1) || (k == 2'd2);
  assign bottom = k[1];

  // ---------------------------------------------------------------- UV
  // Source corner, mirrored when flipped, then divided by the texture size.
  logic [24:0] tu, tv;
  logic [15:0] den_u, den_v;
  assign tu    = {1'b0, spr_tx} + ((right ^ spr_flip[0]) ? {1'b0, spr_tw} : 25'd0);
  assign tv    = {1'b0, spr_ty} + ((bottom ^ spr_flip[1]) ? {1'b0, spr_th} : 25'd0);
  // treat a zero texture size as one
  assign den_u = (texture_width  == '0) ? 16'd1 : texture_width;
  assign den_v = (texture_height == '0) ? 16'd1 : texture_height;

  sqct_div u_div_u (.clk(clk), .num(tu), .den(den_u), .quot(tex_u));
  sqct_div u_div_v (.clk(clk), .num(tv), .den(den_v), .quot(tex_v));

  // ---------------------------------------------------------------- stage A
  // Quarter-wave arguments squared; pivot offsets of the quad.
  logic [14:0] za, zb;
  logic signed [16:0] ox, oy;
  assign za = {1'b0, spr_ang[13:0]};
  assign zb = 15'(sqct_pkg::Q14_ONE) - za;
  assign ox = 17'(origin_x) + 17'sd16384;
  assign oy = 17'(origin_y) + 17'sd16384;

  logic [14:0] a_za, a_zb;
  logic [29:0] a_zza, a_zzb;
  logic [1:0]  a_quad;
  logic signed [41:0] a_offx, a_offy;
  logic [23:0] a_w, a_h;
  logic        a_right, a_bottom;
  logic signed [23:0] a_px, a_py;

  always_ff @(posedge clk) begin
    a_za     <= za;
    a_zb     <= zb;
    a_zza    <= za * za;
    a_zzb    <= zb * zb;
    a_quad   <= spr_ang[15:14];
    a_offx   <= ox * $signed({1'b0, spr_w});
    a_offy   <= oy * $signed({1'b0, spr_h});
    a_w      <= spr_w;
    a_h      <= spr_h;
    a_right  <= right;
    a_bottom <= bottom;
    a_px     <= spr_px;
    a_py     <= spr_py;
  end

  // ---------------------------------------------------------------- stage B
  logic [30:0] zr_a, zr_b;
  logic [14:0] z2a, z2b;
  assign zr_a = 31'(a_zza) + 31'd8192;
  assign zr_b = 31'(a_zzb) + 31'd8192;
  assign z2a  = zr_a[28:14];
  assign z2b  = zr_b[28:14];

  logic [14:0] b_za, b_zb, b_z2a, b_z2b;
  logic [25:0] b_cza, b_czb;
  logic [1:0]  b_quad;
  logic signed [43:0] b_lx, b_ly;
  logic signed [23:0] b_px, b_py;

  always_ff @(posedge clk) begin
    b_za   <= a_za;
    b_zb   <= a_zb;
    b_z2a  <= z2a;
    b_z2b  <= z2b;
    b_cza  <= 11'(sqct_pkg::POLY_C) * z2a;
    b_czb  <= 11'(sqct_pkg::POLY_C) * z2b;
    b_quad <= a_quad;
    b_lx   <= (a_right  ? $signed({5'b0, a_w, 15'b0}) : 44'sd0) - 44'(a_offx);
    b_ly   <= (a_bottom ? $signed({5'b0, a_h, 15'b0}) : 44'sd0) - 44'(a_offy);
    b_px   <= a_px;
    b_py   <= a_py;
  end

  // ---------------------------------------------------------------- stage C
  logic [26:0] ir_a, ir_b;
  logic [13:0] t1a, t1b;
  assign ir_a = 27'(b_cza) + 27'd8192;
  assign ir_b = 27'(b_czb) + 27'd8192;
  assign t1a  = 14'(sqct_pkg::POLY_B) - {3'b0, ir_a[24:14]};
  assign t1b  = 14'(sqct_pkg::POLY_B) - {3'b0, ir_b[24:14]};

  logic [14:0] c_za, c_zb;
  logic [28:0] c_t2a, c_t2b;
  logic [1:0]  c_quad;
  logic signed [43:0] c_lx, c_ly;
  logic signed [23:0] c_px, c_py;

  always_ff @(posedge clk) begin
    c_za   <= b_za;
    c_zb   <= b_zb;
    c_t2a  <= b_z2a * t1a;
    c_t2b  <= b_z2b * t1b;
    c_quad <= b_quad;
    c_lx   <= b_lx;
    c_ly   <= b_ly;
    c_px   <= b_px;
    c_py   <= b_py;
  end

  // ---------------------------------------------------------------- stage D
  logic [29:0] tr_a, tr_b;
  logic [14:0] t3a, t3b;
  assign tr_a = 30'(c_t2a) + 30'd8192;
  assign tr_b = 30'(c_t2b) + 30'd8192;
  assign t3a  = 15'(sqct_pkg::POLY_A) - {1'b0, tr_a[27:14]};
  assign t3b  = 15'(sqct_pkg::POLY_A) - {1'b0, tr_b[27:14]};

  logic [29:0] d_spa, d_spb;
  logic [1:0]  d_quad;
  logic signed [43:0] d_lx, d_ly;
  logic signed [23:0] d_px, d_py;

  always_ff @(posedge clk) begin
    d_spa  <= c_za * t3a;
    d_spb  <= c_zb * t3b;
    d_quad <= c_quad;
    d_lx   <= c_lx;
    d_ly   <= c_ly;
    d_px   <= c_px;
    d_py   <= c_py;
  end

  // ---------------------------------------------------------------- stage E
  // Cap at one and fold the quadrant into sine and cosine.
  logic [30:0] sr_a, sr_b;
  logic [15:0] sa_raw, sb_raw;
  logic signed [15:0] sa, sb, sn, cs;
  assign sr_a   = 31'(d_spa) + 31'd8192;
  assign sr_b   = 31'(d_spb) + 31'd8192;
  assign sa_raw = sr_a[29:14];
  assign sb_raw = sr_b[29:14];
  assign sa = (sa_raw > 16'(sqct_pkg::Q14_ONE)) ? 16'sd16384 : $signed(sa_raw);
  assign sb = (sb_raw > 16'(sqct_pkg::Q14_ONE)) ? 16'sd16384 : $signed(sb_raw);

  always_comb begin
    case (d_quad)
      2'd0:    begin sn = sa;  cs = sb;  end
      2'd1:    begin sn = sb;  cs = -sa; end
      2'd2:    begin sn = -sa; cs = -sb; end
      default: begin sn = -sb; cs = sa;  end
    endcase
  end

  logic signed [15:0] e_sn, e_cs;
  logic signed [43:0] e_lx, e_ly;
  logic signed [23:0] e_px, e_py;

  always_ff @(posedge clk) begin
    e_sn <= sn;
    e_cs <= cs;
    e_lx <= d_lx;
    e_ly <= d_ly;
    e_px <= d_px;
    e_py <= d_py;
  end

  // ---------------------------------------------------------------- stage F
  logic signed [59:0] f_xc, f_ys, f_xs, f_yc;
  logic signed [23:0] f_px, f_py;

  always_ff @(posedge clk) begin
    f_xc <= e_lx * e_cs;
    f_ys <= e_ly * e_sn;
    f_xs <= e_lx * e_sn;
    f_yc <= e_ly * e_cs;
    f_px <= e_px;
    f_py <= e_py;
  end

  // ---------------------------------------------------------------- stage G
  // Rotate and add the rounding half.
  logic signed [60:0] g_vx, g_vy;
  logic signed [23:0] g_px, g_py;

  always_ff @(posedge clk) begin
    g_vx <= 61'(f_xc) - 61'(f_ys) + (61'sd1 <<< 28);
    g_vy <= 61'(f_xs) + 61'(f_yc) + (61'sd1 <<< 28);
    g_px <= f_px;
    g_py <= f_py;
  end

  // ---------------------------------------------------------------- stage H
  // Drop the fraction, move to the placed point and saturate.
  logic signed [32:0] sum_x, sum_y;
  assign sum_x = 33'($signed(g_vx[60:29])) + 33'(g_px);
  assign sum_y = 33'($signed(g_vy[60:29])) + 33'(g_py);

  logic [23:0] pdl_x [0:PDLY];
  logic [23:0] pdl_y [0:PDLY];

  always_ff @(posedge clk) begin
    pdl_x[0] <= sqct_pkg::sat_pos(sum_x);
    pdl_y[0] <= sqct_pkg::sat_pos(sum_y);
    for (int i = 1; i <= PDLY; i++) begin
      pdl_x[i] <= pdl_x[i-1];
      pdl_y[i] <= pdl_y[i-1];
    end
  end

  // ---------------------------------------------------------------- tags
  // Advance valid, corner and colour alongside the divider.
  logic        vl  [0:sqct_pkg::DIV_LAT-1];
  logic [1:0]  kl  [0:sqct_pkg::DIV_LAT-1];
  logic [31:0] cl  [0:sqct_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < sqct_pkg::DIV_LAT; i++) begin
        vl[i] <= 1'b0;
      end
    end else begin
      vl[0] <= active;
      for (int i = 1; i < sqct_pkg::DIV_LAT; i++) begin
        vl[i] <= vl[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    kl[0] <= k;
    cl[0] <= spr_col;
    for (int i = 1; i < sqct_pkg::DIV_LAT; i++) begin
      kl[i] <= kl[i-1];
      cl[i] <= cl[i-1];
    end
  end

  assign result_valid  = vl[sqct_pkg::DIV_LAT-1];
  assign corner        = kl[sqct_pkg::DIV_LAT-1];
  assign vertex_colour = cl[sqct_pkg::DIV_LAT-1];
  assign last          = (kl[sqct_pkg::DIV_LAT-1] == 2'd3);
  assign pos_x         = pdl_x[PDLY];
  assign pos_y         = pdl_y[PDLY];

  // ---------------------------------------------------------------- checks
  a_corner_seq: assert property (@(posedge clk) disable iff (rst)
    result_valid && (corner != 2'd0) |->
      $past(result_valid) && ($past(corner) == corner - 2'd1))
    else $error("vertex corners out of order");

  a_first_corner: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(sqct_pkg::RES_LAT) (result_valid && (corner == 2'd0)))
    else $error("accepted sprite did not yield corner 0 on time");

  a_busy_span: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy ##1 busy ##1 busy ##1 !busy)
    else $error("busy window is not three cycles");

endmodule

// File: rtl/sqct_div.sv
// ============================================================================
// sqct_div : pipelined rounding divider for texture coordinates
// One restoring step per stage; quotient clamps to the Q12.8 maximum.
// ============================================================================
module sqct_div (
  input  logic                             clk,
  input  logic [sqct_pkg::TSUM_W-1:0]      num,
  input  logic [sqct_pkg::DEN_W-1:0]       den,
  output logic [sqct_pkg::UV_W-1:0]        quot
);

  localparam int N_W = sqct_pkg::TSUM_W + 9;
  localparam int R_W = sqct_pkg::DEN_W + sqct_pkg::UV_W;

  logic [N_W-1:0]              n0;
  logic [sqct_pkg::DEN_W-1:0]  d0;

  logic [R_W-1:0]              rem [0:sqct_pkg::DIV_STEPS];
  logic [sqct_pkg::UV_W-1:0]   qq  [0:sqct_pkg::DIV_STEPS];
  logic [sqct_pkg::DEN_W-1:0]  dd  [0:sqct_pkg::DIV_STEPS];
  logic                        ov  [0:sqct_pkg::DIV_STEPS];

  // numerator with half the divisor added for round half up
  always_ff @(posedge clk) begin
    n0 <= {1'b0, num, 8'b0} + N_W'(den >> 1);
    d0 <= den;
  end

  always_ff @(posedge clk) begin
    rem[0] <= R_W'(n0);
    dd[0]  <= d0;
    qq[0]  <= '0;
    ov[0]  <= R_W'(n0) >= {d0, {sqct_pkg::UV_W{1'b0}}};
  end

  for (genvar k = 1; k <= sqct_pkg::DIV_STEPS; k++) begin : g_step
    localparam int B = sqct_pkg::DIV_STEPS - k;
    logic [R_W-1:0] sub;
    assign sub = R_W'(dd[k-1]) << B;
    always_ff @(posedge clk) begin
      dd[k] <= dd[k-1];
      ov[k] <= ov[k-1];
      if (rem[k-1] >= sub) begin
        rem[k] <= rem[k-1] - sub;
        qq[k]  <= qq[k-1] | (sqct_pkg::UV_W'(1) << B);
      end else begin
        rem[k] <= rem[k-1];
        qq[k]  <= qq[k-1];
      end
    end
  end

  assign quot = ov[sqct_pkg::DIV_STEPS] ? '1 : qq[sqct_pkg::DIV_STEPS];

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sprite quad corner transform: self-checking bench
// Drives sprite words through the start/busy port, models each sprite's four
// corner vertices and checks every vertex strobe against that model, over
// several pivot and texture-size settings and three sender idling profiles.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [23:0] px;
    logic [23:0] py;
    logic [19:0] u;
    logic [19:0] v;
    logic [31:0] col;
    logic [1:0]  crn;
    logic        lst;
  } vertex_t;

  typedef struct {
    logic [23:0] plx, ply, plw, plh, tx, ty, tw, th;
    logic [15:0] ang;
    logic [1:0]  flp;
    logic [31:0] col;
  } sprite_t;

  // directed row: known = 1 means every corner has the typed position and UV
  typedef struct {
    sprite_t     s;
    bit          known;
    logic [23:0] kx, ky;
    logic [19:0] ku, kv;
  } sprite_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [23:0] place_x = '0, place_y = '0, place_w = '0, place_h = '0;
  logic [23:0] tex_x = '0, tex_y = '0, tex_w = '0, tex_h = '0;
  logic [15:0] angle = '0;
  logic [1:0]  flip = '0;
  logic [31:0] colour = '0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        result_valid;
  logic [23:0] pos_x, pos_y;
  logic [19:0] tex_u, tex_v;
  logic [31:0] vertex_colour;
  logic [1:0]  corner;
  logic        last;

  // model copy of the configuration registers
  longint pivot_x = 0, pivot_y = 0, tex_width = 1, tex_height = 1;

  vertex_t     pending_vertices[$];
  int          mismatches = 0;
  int          vertices_seen = 0;
  int          sprites_sent = 0;
  int          cfg_writes = 0;
  longint      cycles = 0;
  int          idle_pct = 0;

  localparam longint CYCLE_LIMIT = 2000000;

  sprite_quad_corner_transform_unit u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // quarter-wave sine, z in Q14 of a quarter turn, result Q1.14
  function automatic longint quarter_wave(longint z);
    longint z2, t1, t2, s;
    z2 = (z * z + 8192) >> 14;
    t1 = sqct_pkg::POLY_B - ((sqct_pkg::POLY_C * z2 + 8192) >> 14);
    t2 = sqct_pkg::POLY_A - ((z2 * t1 + 8192) >> 14);
    s  = (z * t2 + 8192) >> 14;
    return (s > sqct_pkg::Q14_ONE) ? sqct_pkg::Q14_ONE : s;
  endfunction

  function automatic logic [23:0] clamp_pos(longint v);
    if (v > 8388607) return 24'h7FFFFF;
    if (v < -8388608) return 24'h800000;
    return v[23:0];
  endfunction

  function automatic logic [19:0] uv_of(longint t, longint size);
    longint d, q;
    d = (size == 0) ? 1 : size;
    q = (t * 256 + (d >> 1)) / d;
    return (q > 1048575) ? 20'hFFFFF : q[19:0];
  endfunction

  // work out the four corner vertices of one sprite and queue them
  task automatic queue_corners(sprite_t s, bit known, logic [23:0] kx, logic [23:0] ky,
                               logic [19:0] ku, logic [19:0] kv);
    longint px, py, w, h, a, b, sn, cs, offx, offy, lx, ly;
    bit right, bottom;
    vertex_t vx;
    px = longint'(signed'(s.plx));
    py = longint'(signed'(s.ply));
    w = s.plw;
    h = s.plh;
    a = quarter_wave(s.ang[13:0]);
    b = quarter_wave(sqct_pkg::Q14_ONE - s.ang[13:0]);
    case (s.ang[15:14])
      2'd0: begin sn = a;  cs = b;  end
      2'd1: begin sn = b;  cs = -a; end
      2'd2: begin sn = -a; cs = -b; end
      default: begin sn = -b; cs = a; end
    endcase
    offx = (pivot_x + sqct_pkg::Q14_ONE) * w;
    offy = (pivot_y + sqct_pkg::Q14_ONE) * h;
    for (int k = 0; k < 4; k++) begin
      right = (k == 1 || k == 2);
      bottom = (k >= 2);
      lx = (right ? w * 32768 : 0) - offx;
      ly = (bottom ? h * 32768 : 0) - offy;
      // one half-up rounding of the rotated Q15+14 value
      vx.px = clamp_pos(((lx * cs - ly * sn + (longint'(1) << 28)) >>> 29) + px);
      vx.py = clamp_pos(((lx * sn + ly * cs + (longint'(1) << 28)) >>> 29) + py);
      vx.u = uv_of(longint'(s.tx) + ((right != s.flp[0]) ? longint'(s.tw) : 0), tex_width);
      vx.v = uv_of(longint'(s.ty) + ((bottom != s.flp[1]) ? longint'(s.th) : 0), tex_height);
      if (known) begin
        vx.px = kx; vx.py = ky; vx.u = ku; vx.v = kv;
      end
      vx.col = s.col;
      vx.crn = k[1:0];
      vx.lst = (k == 3);
      pending_vertices.push_back(vx);
    end
  endtask

  // present one sprite word and hold it until accepted
  task automatic send_sprite(sprite_t s, bit known = 0, logic [23:0] kx = '0,
                             logic [23:0] ky = '0, logic [19:0] ku = '0, logic [19:0] kv = '0);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    {place_x, place_y, place_w, place_h} = {s.plx, s.ply, s.plw, s.plh};
    {tex_x, tex_y, tex_w, tex_h} = {s.tx, s.ty, s.tw, s.th};
    {angle, flip, colour} = {s.ang, s.flp, s.col};
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    queue_corners(s, known, kx, ky, ku, kv);
    sprites_sent++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic write_reg(sqct_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      sqct_pkg::REG_ORIGIN_X:      pivot_x = longint'(signed'(val));
      sqct_pkg::REG_ORIGIN_Y:      pivot_y = longint'(signed'(val));
      sqct_pkg::REG_TEXTURE_WIDTH: tex_width = val;
      default:                     tex_height = val;
    endcase
    cfg_writes++;
  endtask

  // drain: wait for every queued vertex, then let the pipe settle
  task automatic drain();
    while (pending_vertices.size() != 0) @(negedge clk);
    repeat (sqct_pkg::RES_LAT + 8) @(negedge clk);
  endtask

  // pick a 24-bit size: mostly small, sometimes any value
  function automatic logic [23:0] rand_size();
    case ($urandom_range(9))
      0: return 24'($urandom);
      1: return 24'hFFFFFF;
      default: return 24'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic sprite_t rand_sprite();
    sprite_t s;
    s.plx = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(20'hFFFFF));
    s.ply = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(20'hFFFFF));
    s.plw = rand_size();
    s.plh = rand_size();
    s.tx  = rand_size();
    s.ty  = rand_size();
    s.tw  = rand_size();
    s.th  = rand_size();
    case ($urandom_range(7))
      0: s.ang = 16'($urandom_range(3)) << 14;
      default: s.ang = 16'($urandom);
    endcase
    s.flp = 2'($urandom);
    s.col = $urandom;
    return s;
  endfunction

  // compare each vertex strobe with the oldest expectation
  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst && result_valid) begin
      got = '{pos_x, pos_y, tex_u, tex_v, vertex_colour, corner, last};
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected vertex word %h", got);
      end else begin
        want = pending_vertices.pop_front();
        if (got.px !== want.px || got.py !== want.py || got.u !== want.u ||
            got.v !== want.v || got.col !== want.col || got.crn !== want.crn ||
            got.lst !== want.lst) begin
          mismatches++;
          if (mismatches <= 10)
            $display("vertex mismatch: pos %h,%h uv %h,%h col %h c%0d l%0d, expected pos %h,%h uv %h,%h col %h c%0d l%0d",
                     got.px, got.py, got.u, got.v, got.col, got.crn, got.lst,
                     want.px, want.py, want.u, want.v, want.col, want.crn, want.lst);
        end
      end
    end
  end

  sprite_row_t directed[$];
  sprite_t     zs;

  initial begin
    sprite_row_t r;
    logic [15:0] ox, oy, twd, tht;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // build the directed table; zero-size sprites land on the placed point
    zs = '{default: '0};
    r = '{s: zs, known: 1, kx: 24'd100, ky: -24'sd200, ku: 0, kv: 0};
    r.s.plx = 24'd100; r.s.ply = -24'sd200; r.s.col = 32'hDEADBEEF;
    directed.push_back(r);
    r = '{s: zs, known: 1, kx: 24'h7FFFFF, ky: 24'h800000, ku: 0, kv: 0};
    r.s.plx = 24'h7FFFFF; r.s.ply = 24'h800000; r.s.ang = 16'hFFFF; r.s.col = '1;
    directed.push_back(r);
    // texture size one: large source corner saturates UV
    r = '{s: zs, known: 1, kx: 0, ky: 0, ku: 20'hFFFFF, kv: 20'hFFFFF};
    r.s.tx = 24'hFFFFFF; r.s.ty = 24'hFFFFFF; r.s.flp = 2'd3;
    directed.push_back(r);
    r = '{s: zs, known: 1, kx: 0, ky: 0, ku: 20'd2560, kv: 20'd5120};
    r.s.tx = 24'd10; r.s.ty = 24'd20;
    directed.push_back(r);
    // eighth-turn angles and angles beside zero, every flip combination, full-size quads
    for (int i = 0; i < 16; i++) begin
      r = '{s: zs, known: 0, kx: 0, ky: 0, ku: 0, kv: 0};
      r.s.plx = 24'd2560; r.s.ply = 24'd1280;
      r.s.plw = (i == 12) ? 24'hFFFFFF : 24'd8192;
      r.s.plh = (i == 13) ? 24'hFFFFFF : 24'd4096;
      r.s.tx = 24'd256; r.s.ty = 24'd512; r.s.tw = 24'd1024; r.s.th = 24'd768;
      r.s.ang = (i < 8) ? 16'(i) << 13 : ((i == 14) ? 16'hFFFF : 16'd1);
      r.s.flp = i[1:0];
      r.s.col = 32'h01020304 * i;
      directed.push_back(r);
    end

    foreach (directed[i])
      send_sprite(directed[i].s, directed[i].known, directed[i].kx, directed[i].ky,
                  directed[i].ku, directed[i].kv);
    drain();

    // settings phases: extremes first, then random, each with a block of sprites
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin ox = -16'sd16384; oy = 16'sd16384; twd = 16'd0; tht = 16'hFFFF; end
        1: begin ox = 16'sd16384; oy = -16'sd16384; twd = 16'hFFFF; tht = 16'd1; end
        2: begin ox = 16'h8000; oy = 16'h7FFF; twd = 16'd1; tht = 16'd0; end
        3: begin ox = 16'h7FFF; oy = 16'h8000; twd = 16'd3; tht = 16'd7; end
        default: begin
          ox = 16'($urandom_range(32768) - 16384);
          oy = 16'($urandom_range(32768) - 16384);
          twd = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
          tht = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 4096));
        end
      endcase
      write_reg(sqct_pkg::REG_ORIGIN_X, ox);
      write_reg(sqct_pkg::REG_ORIGIN_Y, oy);
      write_reg(sqct_pkg::REG_TEXTURE_WIDTH, twd);
      write_reg(sqct_pkg::REG_TEXTURE_HEIGHT, tht);
      // sender idling: light, then heavy, then none
      idle_pct = (ph < 3) ? 13 : ((ph < 7) ? 81 : 0);
      for (int n = 0; n < 48; n++) send_sprite(rand_sprite());
      drain();
    end

    $display("covered %0d sprites, %0d vertex words, %0d register writes",
             sprites_sent, vertices_seen, cfg_writes);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
